### sv/prms_pkg.sv
`default_nettype none

package prms_pkg;

    localparam int ACT_W   = 2;
    localparam int KEY_W   = 16;
    localparam int MAG_W   = 15;
    localparam int PAY_W   = 64;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Request codes.
    localparam logic [ACT_W-1:0] ACT_SAVE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TAKE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_STORED   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REPLACED = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd3;

    // Control half of the scan packet that walks the cell chain.
    typedef struct packed {
        logic             active;
        logic [ACT_W-1:0] op;
        logic             full;
        logic             hit;
        logic             in_range;
    } t_scan_ctl;

    // Data half of the scan packet: the new message on a save, the best
    // message found so far on a take-best.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic [MAG_W-1:0] mag;
    } t_scan_msg;

    // The sign bit is dropped; the remaining bits order finite half values.
    function automatic logic [MAG_W-1:0] key_mag(input logic [KEY_W-1:0] k);
        return k[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/prms_cell.sv
`default_nettype none

module prms_cell
    import prms_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_scan_ctl     i_ctl,
    input  wire logic [IW-1:0] i_idx,
    input  wire t_scan_msg     i_msg,
    output t_scan_ctl          o_ctl,
    output logic [IW-1:0]      o_idx,
    output t_scan_msg          o_msg
);

    logic             r_valid;
    logic [KEY_W-1:0] r_height;
    logic [PAY_W-1:0] r_payload;
    t_scan_ctl        r_ctl;
    logic [IW-1:0]    r_idx;
    t_scan_msg        r_msg;

    logic             n_valid;
    logic [KEY_W-1:0] n_height;
    logic [PAY_W-1:0] n_payload;
    t_scan_ctl        n_ctl;
    logic [IW-1:0]    n_idx;
    t_scan_msg        n_msg;

    logic [MAG_W-1:0] w_own_mag;
    logic             w_better;

    assign w_own_mag = key_mag(r_height);
    assign w_better  = r_valid && (w_own_mag > i_msg.mag);

    always_comb begin
        n_valid   = r_valid;
        n_height  = r_height;
        n_payload = r_payload;
        n_ctl     = i_ctl;
        n_idx     = i_idx;
        n_msg     = i_msg;
        if (i_ctl.active) begin
            case (i_ctl.op)
                ACT_SAVE: begin
                    // First free slot, or when full the first smaller key.
                    if (!i_ctl.hit && (i_ctl.full ? (w_own_mag < key_mag(i_msg.key))
                                                  : !r_valid)) begin
                        n_valid   = 1'b1;
                        n_height  = i_msg.key;
                        n_payload = i_msg.pay;
                        n_ctl.hit = 1'b1;
                        n_idx     = IW'(IDX);
                    end
                end
                ACT_TAKE: begin
                    if (w_better) begin
                        n_msg.mag = w_own_mag;
                    end
                    // Slot 0 always loads the packet so it wins by default.
                    if (w_better || (IDX == 0)) begin
                        n_idx     = IW'(IDX);
                        n_msg.key = r_height;
                        n_msg.pay = r_payload;
                    end
                end
                ACT_DELETE: begin
                    if (i_ctl.in_range && (i_idx == IW'(IDX))) begin
                        n_valid   = 1'b0;
                        n_height  = '0;
                        n_payload = '0;
                    end
                end
                ACT_CLEAR: begin
                    n_valid   = 1'b0;
                    n_height  = '0;
                    n_payload = '0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_height  <= '0;
            r_payload <= '0;
            r_ctl     <= '0;
        end else begin
            r_valid   <= n_valid;
            r_height  <= n_height;
            r_payload <= n_payload;
            r_ctl     <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_msg <= n_msg;
    end

    assign o_ctl = r_ctl;
    assign o_idx = r_idx;
    assign o_msg = r_msg;

endmodule

`default_nettype wire

### sv/priority_retention_message_store.sv
// Message store that keeps the highest-priority messages in SLOTS slots.
// Input channel (i_valid / o_ready) carries one request: save a message,
// take the best message, delete one slot, or clear the whole store.
// Output channel (o_valid / i_ready) returns exactly one result per request:
// a status, the slot touched, the best message on a take-best, and the
// number of messages held after the request.
// Each slot lives in its own cell; a request travels down the row of cells
// as a scan packet, one cell per cycle, and each cell updates its slot as the
// packet passes. The result is formed from the packet leaving the last cell,
// and a new request is taken only once the previous result has moved into
// the output register.
// A finished result sits in the output register, so the next request is
// accepted while the receiver stalls; that request completes its scan and
// then waits in a holding register until the output register frees up.
// Reset empties every slot, clears the count and drops any request in flight.
`default_nettype none

module priority_retention_message_store
    import prms_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [ACT_W-1:0]   i_action,
    input  wire logic [KEY_W-1:0]   i_wave_height,
    input  wire logic [PAY_W-1:0]   i_payload_in,
    input  wire logic [SLOT_W-1:0]  i_slot_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [STAT_W-1:0]       o_status,
    output logic [SLOT_W-1:0]       o_slot_out,
    output logic [PAY_W-1:0]        o_payload_out,
    output logic [KEY_W-1:0]        o_height_out,
    output logic [COUNT_W-1:0]      o_stored_count
);

    // Index width covers both the slot range and the slot field of a request.
    localparam int IW = ($clog2(SLOTS) > SLOT_W) ? $clog2(SLOTS) : SLOT_W;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;

    // Launch register feeding the first cell.
    t_scan_ctl     r_l_ctl;
    logic [IW-1:0] r_l_idx;
    t_scan_msg     r_l_msg;

    // Chain taps: entry 0 is the launch register, entry SLOTS the last cell.
    t_scan_ctl     w_ctl [SLOTS+1];
    logic [IW-1:0] w_idx [SLOTS+1];
    t_scan_msg     w_msg [SLOTS+1];

    // Result waiting for the output register.
    logic [STAT_W-1:0] r_h_status;
    logic [SLOT_W-1:0] r_h_slot;
    logic [PAY_W-1:0]  r_h_pay;
    logic [KEY_W-1:0]  r_h_key;

    logic [STAT_W-1:0] n_status;
    logic [SLOT_W-1:0] n_slot;
    logic [PAY_W-1:0]  n_pay;
    logic [KEY_W-1:0]  n_key;

    logic          w_acc;
    logic          w_done;
    logic          w_load;
    logic [IW-1:0] w_slot_ext;
    logic          w_in_range;
    t_scan_ctl     w_end;

    assign o_ready    = (r_state == S_IDLE);
    assign w_acc      = i_valid && o_ready;
    assign w_end      = w_ctl[SLOTS];
    assign w_done     = (r_state == S_SCAN) && w_end.active;
    assign w_load     = (r_state == S_HOLD) && (!o_valid || i_ready);
    assign w_slot_ext = IW'(i_slot_in);
    assign w_in_range = {1'b0, w_slot_ext} < (IW + 1)'(SLOTS);

    assign w_ctl[0] = r_l_ctl;
    assign w_idx[0] = r_l_idx;
    assign w_msg[0] = r_l_msg;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        prms_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_idx   (w_idx[g]),
            .i_msg   (w_msg[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_msg   (w_msg[g+1])
        );
    end

    // Form the result from the packet leaving the last cell.
    always_comb begin
        n_status = STAT_EMPTY;
        n_slot   = '0;
        n_pay    = '0;
        n_key    = '0;
        case (w_end.op)
            ACT_SAVE: begin
                if (w_end.hit) begin
                    n_status = w_end.full ? STAT_REPLACED : STAT_STORED;
                    n_slot   = SLOT_W'(w_idx[SLOTS]);
                end else begin
                    n_status = STAT_DROPPED;
                end
            end
            ACT_TAKE: begin
                // The count is untouched by a take, so it still tells empty.
                if (r_count != '0) begin
                    n_status = STAT_STORED;
                    n_slot   = SLOT_W'(w_idx[SLOTS]);
                    n_pay    = w_msg[SLOTS].pay;
                    n_key    = w_msg[SLOTS].key;
                end
            end
            ACT_DELETE: begin
                if (w_end.in_range) begin
                    n_status = STAT_STORED;
                    n_slot   = SLOT_W'(w_idx[SLOTS]);
                end
            end
            ACT_CLEAR: begin
                n_status = STAT_EMPTY;
            end
            default: begin
                n_status = STAT_EMPTY;
            end
        endcase
    end

    // Control: state, count, launch valid and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_l_ctl <= '0;
            o_valid <= 1'b0;
        end else begin
            r_l_ctl.active <= w_acc;
            if (w_acc) begin
                r_l_ctl.op       <= i_action;
                r_l_ctl.full     <= (r_count == CW'(SLOTS));
                r_l_ctl.hit      <= 1'b0;
                r_l_ctl.in_range <= w_in_range;
                // Delete and clear settle the count right away; a save that
                // lands in a free slot bumps it when the scan comes back.
                if ((i_action == ACT_DELETE) && w_in_range && (r_count != '0)) begin
                    r_count <= r_count - CW'(1);
                end else if (i_action == ACT_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (w_done && (w_end.op == ACT_SAVE) && w_end.hit && !w_end.full) begin
                r_count <= r_count + CW'(1);
            end
            if (w_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_l_idx     <= (i_action == ACT_DELETE) ? w_slot_ext : '0;
            r_l_msg.key <= i_wave_height;
            r_l_msg.pay <= i_payload_in;
            r_l_msg.mag <= '0;
        end
        if (w_done) begin
            r_h_status <= n_status;
            r_h_slot   <= n_slot;
            r_h_pay    <= n_pay;
            r_h_key    <= n_key;
        end
        if (w_load) begin
            o_status       <= r_h_status;
            o_slot_out     <= r_h_slot;
            o_payload_out  <= r_h_pay;
            o_height_out   <= r_h_key;
            o_stored_count <= COUNT_W'(r_count);
        end
    end

endmodule

`default_nettype wire

### sv/prms_checker.sv
`default_nettype none

module prms_checker
    import prms_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic [ACT_W-1:0]   i_action,
    input wire logic [KEY_W-1:0]   i_wave_height,
    input wire logic [PAY_W-1:0]   i_payload_in,
    input wire logic [SLOT_W-1:0]  i_slot_in,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [STAT_W-1:0]  o_status,
    input wire logic [SLOT_W-1:0]  o_slot_out,
    input wire logic [PAY_W-1:0]   o_payload_out,
    input wire logic [KEY_W-1:0]   o_height_out,
    input wire logic [COUNT_W-1:0] o_stored_count
);

    // A stalled result holds its payload, status and slot.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_payload_out) &&
                                   $stable(o_status) && $stable(o_slot_out)))
        else $error("stalled result changed");

    // One request at a time: an accepted request closes the input side.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while another is in flight");

    // An empty status touches no slot and reports no message.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_EMPTY)) |->
            ((o_slot_out == '0) && (o_payload_out == '0) && (o_height_out == '0)))
        else $error("empty result carries data");

    // A dropped message names no slot.
    a_drop_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_DROPPED)) |-> (o_slot_out == '0))
        else $error("dropped message reports a slot");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind priority_retention_message_store prms_checker u_prms_checker (.*);

`default_nettype wire

### tb/priority_retention_message_store_checker.sv
`timescale 1ns / 100ps
`default_nettype none

// Watches both channels of the message store and tracks the slot table on
// its own. Every accepted request produces one expected result, and every
// accepted result is compared with the oldest one still outstanding.
module priority_retention_message_store_checker
    import prms_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire logic               i_req_ready,
    input  wire logic [ACT_W-1:0]   i_action,
    input  wire logic [KEY_W-1:0]   i_wave_height,
    input  wire logic [PAY_W-1:0]   i_payload_in,
    input  wire logic [SLOT_W-1:0]  i_slot_in,
    input  wire logic               i_res_valid,
    input  wire logic               i_res_ready,
    input  wire logic [STAT_W-1:0]  i_status,
    input  wire logic [SLOT_W-1:0]  i_slot_out,
    input  wire logic [PAY_W-1:0]   i_payload_out,
    input  wire logic [KEY_W-1:0]   i_height_out,
    input  wire logic [COUNT_W-1:0] i_stored_count,
    output int                      o_err_count,
    output int                      o_pending,
    output int                      o_results
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [PAY_W-1:0]   pay;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_store_result;

    logic              slot_used [SLOTS];
    logic [KEY_W-1:0]  slot_key  [SLOTS];
    logic [PAY_W-1:0]  slot_pay  [SLOTS];
    int unsigned       msg_count;

    t_store_result     expected_results [$];
    int                err_count = 0;
    int                result_count = 0;

    function automatic void empty_store();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_pay[i]  = '0;
        end
        msg_count = 0;
    endfunction

    function automatic void store_message(input int idx, input logic [KEY_W-1:0] key,
                                          input logic [PAY_W-1:0] pay);
        slot_used[idx] = 1'b1;
        slot_key[idx]  = key;
        slot_pay[idx]  = pay;
    endfunction

    // Applies one request to the tracked table and returns the result the
    // store must report for it.
    function automatic t_store_result apply_request(input logic [ACT_W-1:0] act,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [PAY_W-1:0] pay,
                                                    input logic [SLOT_W-1:0] slot);
        t_store_result    r;
        int               i;
        bit               done;
        logic [MAG_W-1:0] best;
        int               best_idx;
        r = '0;
        done = 1'b0;
        case (act)
            ACT_SAVE: begin
                r.status = STAT_DROPPED;
                if (msg_count == SLOTS) begin
                    // Full: the first slot with a smaller magnitude is replaced.
                    for (i = 0; i < SLOTS; i++) begin
                        if (!done && slot_key[i][MAG_W-1:0] < key[MAG_W-1:0]) begin
                            store_message(i, key, pay);
                            r.status = STAT_REPLACED;
                            r.slot = SLOT_W'(i);
                            done = 1'b1;
                        end
                    end
                end else begin
                    // Not full: the first free slot, if any is free at all.
                    for (i = 0; i < SLOTS; i++) begin
                        if (!done && !slot_used[i]) begin
                            store_message(i, key, pay);
                            msg_count++;
                            r.status = STAT_STORED;
                            r.slot = SLOT_W'(i);
                            done = 1'b1;
                        end
                    end
                end
            end
            ACT_TAKE: begin
                if (msg_count != 0) begin
                    best = '0;
                    best_idx = 0;
                    for (i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot_key[i][MAG_W-1:0] > best) begin
                            best = slot_key[i][MAG_W-1:0];
                            best_idx = i;
                        end
                    end
                    r.status = STAT_STORED;
                    r.slot = SLOT_W'(best_idx);
                    r.pay = slot_pay[best_idx];
                    r.key = slot_key[best_idx];
                end
            end
            ACT_DELETE: begin
                if (int'(slot) < SLOTS) begin
                    slot_used[slot] = 1'b0;
                    slot_key[slot]  = '0;
                    slot_pay[slot]  = '0;
                    if (msg_count != 0) msg_count--;
                    r.status = STAT_STORED;
                    r.slot = slot;
                end
            end
            default: begin
                empty_store();
            end
        endcase
        r.count = msg_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_result();
        t_store_result got;
        t_store_result want;
        got = {i_status, i_slot_out, i_payload_out, i_height_out, i_stored_count};
        result_count++;
        if (expected_results.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("%0t: result with no request outstanding: status %0d slot %0d",
                         $realtime, got.status, got.slot);
        end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("%0t: result %0d mismatch (expected / actual):",
                             $realtime, result_count);
                    $display("  status %0d / %0d, slot %0d / %0d, count %0d / %0d",
                             want.status, got.status, want.slot, got.slot,
                             want.count, got.count);
                    $display("  payload %h / %h, height %h / %h",
                             want.pay, got.pay, want.key, got.key);
                end
            end
        end
    endtask

    initial empty_store();

    // Results are checked before the request of the same edge is applied;
    // no request can complete in the cycle it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            empty_store();
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                check_result();
            if (i_req_valid && i_req_ready)
                expected_results.push_back(apply_request(i_action, i_wave_height,
                                                         i_payload_in, i_slot_in));
        end
        o_err_count <= err_count;
        o_pending   <= expected_results.size();
        o_results   <= result_count;
    end

endmodule

`default_nettype wire

### tb/priority_retention_message_store_tb.sv
`timescale 1ns / 100ps
`default_nettype none

// Testbench top for the priority retention message store. This module only
// produces requests, plays the receiver and decides the verdict; all
// prediction and comparison lives in the checker instantiated next to the
// store.
module priority_retention_message_store_tb;
    import prms_pkg::*;

    localparam int SLOTS           = 16;
    localparam int RANDOM_REQUESTS = 1250;
    localparam int HOLD_OFF_CYCLES = 400;
    // The longest quiet stretch in a correct run is the receiver hold-off
    // plus one scan of the chain, so this leaves a wide margin.
    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 60;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [ACT_W-1:0]   i_action;
    logic [KEY_W-1:0]   i_wave_height;
    logic [PAY_W-1:0]   i_payload_in;
    logic [SLOT_W-1:0]  i_slot_in;
    logic               o_valid;
    logic               i_ready;
    logic [STAT_W-1:0]  o_status;
    logic [SLOT_W-1:0]  o_slot_out;
    logic [PAY_W-1:0]   o_payload_out;
    logic [KEY_W-1:0]   o_height_out;
    logic [COUNT_W-1:0] o_stored_count;

    int err_count;
    int pending;
    int results;

    // Shared between the request side and the receiver: quiet_mode turns
    // off idling on both sides, long_stall_req asks the receiver for one
    // long hold-off.
    bit quiet_mode = 1'b0;
    bit long_stall_req = 1'b0;
    int hold_offs = 0;
    int idle_cycles = 0;
    int sent_total = 0;
    int sent_by_action [4] = '{0, 0, 0, 0};

    always #1 i_clk = ~i_clk;

    priority_retention_message_store #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_wave_height  (i_wave_height),
        .i_payload_in   (i_payload_in),
        .i_slot_in      (i_slot_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_slot_out     (o_slot_out),
        .o_payload_out  (o_payload_out),
        .o_height_out   (o_height_out),
        .o_stored_count (o_stored_count)
    );

    priority_retention_message_store_checker #(
        .SLOTS(SLOTS)
    ) store_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_action       (i_action),
        .i_wave_height  (i_wave_height),
        .i_payload_in   (i_payload_in),
        .i_slot_in      (i_slot_in),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_status       (o_status),
        .i_slot_out     (o_slot_out),
        .i_payload_out  (o_payload_out),
        .i_height_out   (o_height_out),
        .i_stored_count (o_stored_count),
        .o_err_count    (err_count),
        .o_pending      (pending),
        .o_results      (results)
    );

    // Idle gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode) return 0;
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Keys lean toward the extremes and toward a narrow band of small
    // magnitudes, so that ties, replacements and drops all come up often.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        logic sign;
        r = $urandom_range(0, 99);
        sign = 1'($urandom_range(0, 1));
        if (r < 10) return 16'h0000;
        if (r < 15) return 16'h8000;
        if (r < 20) return 16'h7FFF;
        if (r < 25) return 16'hFFFF;
        if (r < 60) return {sign, 15'($urandom_range(0, 40))};
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [PAY_W-1:0] pick_pay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        return SLOT_W'($urandom_range(0, SLOTS - 1));
    endfunction

    // Offers one request and returns at the edge where it is accepted. The
    // valid line is only lowered when a gap precedes the next request.
    task automatic send_req(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                            input logic [PAY_W-1:0] pay, input logic [SLOT_W-1:0] slot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_wave_height <= key;
        i_payload_in  <= pay;
        i_slot_in     <= slot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_total++;
        sent_by_action[act]++;
    endtask

    // Fills the table from empty (most of the time) and then keeps saving,
    // which drives the full-table paths: replacement of the first smaller
    // key and dropping when no key is smaller.
    task automatic fill_store();
        int n;
        if ($urandom_range(0, 9) < 7)
            send_req(ACT_CLEAR, pick_key(), pick_pay(), pick_slot());
        n = SLOTS + $urandom_range(0, 10);
        repeat (n) begin
            if ($urandom_range(0, 99) < 15)
                send_req(ACT_TAKE, pick_key(), pick_pay(), pick_slot());
            send_req(ACT_SAVE, pick_key(), pick_pay(), pick_slot());
        end
    endtask

    // Deletes and saves on whatever the table holds. Deleting the same slot
    // twice makes the count fall below the number of used slots, so a later
    // save finds the table not full and yet without a free slot.
    task automatic churn_store();
        int n;
        int r;
        logic [SLOT_W-1:0] s;
        if ($urandom_range(0, 9) < 3) begin
            s = pick_slot();
            send_req(ACT_DELETE, pick_key(), pick_pay(), s);
            send_req(ACT_DELETE, pick_key(), pick_pay(), s);
            send_req(ACT_SAVE, pick_key(), pick_pay(), pick_slot());
            send_req(ACT_SAVE, pick_key(), pick_pay(), pick_slot());
        end
        n = $urandom_range(4, 12);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_req(ACT_DELETE, pick_key(), pick_pay(), pick_slot());
            else if (r < 75)
                send_req(ACT_SAVE, pick_key(), pick_pay(), pick_slot());
            else
                send_req(ACT_TAKE, pick_key(), pick_pay(), pick_slot());
        end
    endtask

    // A table holding only zero-magnitude keys: take-best must fall back to
    // slot 0, including the case where slot 0 itself has been deleted.
    task automatic zero_key_store();
        int n;
        send_req(ACT_CLEAR, pick_key(), pick_pay(), pick_slot());
        n = $urandom_range(1, 4);
        repeat (n)
            send_req(ACT_SAVE, {1'($urandom_range(0, 1)), 15'h0}, pick_pay(), pick_slot());
        if ($urandom_range(0, 1))
            send_req(ACT_DELETE, pick_key(), pick_pay(), '0);
        send_req(ACT_TAKE, pick_key(), pick_pay(), pick_slot());
    endtask

    // Anything goes: every field random, every action equally likely.
    task automatic random_noise();
        int n;
        n = $urandom_range(5, 15);
        repeat (n)
            send_req(ACT_W'($urandom_range(0, 3)), 16'($urandom), {$urandom, $urandom},
                     pick_slot());
    endtask

    // Receiver: random ready stretches and gaps, plus the long hold-off on
    // request, during which the store backs up and drops o_ready.
    initial begin
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_offs++;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Watchdog: a run in which neither channel moves for too long is hung.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("priority_retention_message_store_tb: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int seq_idx;
        int kind;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ACT_SAVE;
        i_wave_height = '0;
        i_payload_in  = '0;
        i_slot_in     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: empty-store take-best, delete of an empty slot
        // with the count saturating at zero, the slot 0 fallback when no key
        // is above zero (valid and then deleted), ties at the largest
        // magnitude, clear, and the field extremes.
        send_req(ACT_TAKE,   16'hFFFF, '1, 4'hF);
        send_req(ACT_DELETE, 16'h0000, '0, 4'hF);
        send_req(ACT_SAVE,   16'h8000, '1, 4'h0);
        send_req(ACT_SAVE,   16'h0000, '0, 4'hF);
        send_req(ACT_TAKE,   16'h0000, '0, 4'h0);
        send_req(ACT_DELETE, 16'hFFFF, '1, 4'h0);
        send_req(ACT_TAKE,   16'h0000, '0, 4'h0);
        send_req(ACT_SAVE,   16'hFFFF, 64'h0123_4567_89AB_CDEF, 4'h0);
        send_req(ACT_SAVE,   16'h7FFF, 64'hFEDC_BA98_7654_3210, 4'hF);
        send_req(ACT_TAKE,   16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 4'hA);
        send_req(ACT_DELETE, 16'hAAAA, 64'h5555_5555_5555_5555, 4'h1);
        send_req(ACT_SAVE,   16'h0001, 64'h8000_0000_0000_0001, 4'h5);
        send_req(ACT_TAKE,   16'h0000, '0, 4'h0);
        send_req(ACT_CLEAR,  16'hFFFF, '1, 4'hF);
        send_req(ACT_TAKE,   16'h0000, '0, 4'h0);

        // Random part: mostly well-formed sequences that reach a full table,
        // with some stretches where neither side idles.
        seq_idx = 0;
        while (sent_by_action[0] + sent_by_action[1] + sent_by_action[2]
               + sent_by_action[3] < 15 + RANDOM_REQUESTS) begin
            quiet_mode = ($urandom_range(0, 5) == 0);
            if (seq_idx == 4 || seq_idx == 40)
                long_stall_req = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 45)
                fill_store();
            else if (kind < 65)
                churn_store();
            else if (kind < 80)
                zero_key_store();
            else
                random_noise();
            seq_idx++;
        end
        quiet_mode = 1'b0;

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d saves, %0d take-best, %0d deletes, %0d clears.",
                 sent_total, sent_by_action[0], sent_by_action[1], sent_by_action[2],
                 sent_by_action[3]);
        $display("Compared %0d results; receiver held off %0d times for %0d cycles each.",
                 results, hold_offs, HOLD_OFF_CYCLES);
        if (err_count == 0 && pending == 0) begin
            $display("priority_retention_message_store_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", err_count, pending);
            $display("priority_retention_message_store_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
